### sv/q2e_pkg.sv
package q2e_pkg;

  // Configuration register indexes
  localparam logic CFG_EULER_ORDER      = 1'b0;
  localparam logic CFG_GIMBAL_THRESHOLD = 1'b1;

  // Bit positions inside the axis order code
  localparam int ORD_FRAME  = 0;
  localparam int ORD_REPEAT = 1;
  localparam int ORD_PARITY = 2;
  localparam int ORD_AXIS   = 3;

  // Angle format inside the CORDIC: radians * 2^24
  localparam int ZW      = 28;
  localparam int TAB_LEN = 24;
  localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [16:0]   ANG_OUT_MAX = 17'sd25736;

  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  // Next axis in the cyclic order x -> y -> z -> x
  function automatic logic [1:0] axis_succ(input logic [1:0] a);
    logic [1:0] r;
    case (a)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

### sv/quaternion_to_euler_any_order.sv
// Quaternion to Euler angles for any of the 24 axis orders (Graphics Gems
// order code). Each request carries one quaternion in signed Q1.14, not
// necessarily unit length; each result carries three angles in radians*8192
// and a flag that marks the singular (gimbal lock) branch, where the third
// angle is forced to zero. The matrix is scaled by 2/|q|^2 with exact
// rounded division, and a zero quaternion gives the identity. The block is a
// fully pipelined datapath: it takes one request every clock while the output
// is not stalled. Its stages include the one-bit-per-stage dividers (DATA_WIDTH
// stages), the one-bit-per-stage square root (DATA_WIDTH-1 stages) and the
// CORDIC (CORDIC_STAGES stages). A stall on the output holds every stage;
// write the order and threshold registers only while no request is in flight.
module quaternion_to_euler_any_order #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // angle_first, angle_second, angle_third
  output logic [0:0]  m_tuser,   // near_gimbal_lock
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int F   = DATA_WIDTH - 2;  // matrix fraction bits
  localparam int QW  = F + 2;           // quotient width
  localparam int MW  = F + 2;           // signed matrix entry width
  localparam int SW  = F + 1;           // square root width
  localparam int NQW = 33;              // squared norm width
  localparam int HW  = 33;              // half numerator width
  localparam int RW  = NQW + 1;         // divider remainder width
  localparam int DVW = F + 34;          // dividend width
  localparam int RMW = SW + 3;          // square root remainder width
  localparam int XW  = F + 12;          // CORDIC x/y width
  localparam int ZW  = q2e_pkg::ZW;
  localparam int CS  = CORDIC_STAGES;
  localparam int LAT = 3 + QW + 2 + 2 + SW + 2 + CS + 1;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [4:0]  euler_order;
  logic [13:0] gimbal_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      euler_order      <= 5'd0;
      gimbal_threshold <= 14'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        q2e_pkg::CFG_EULER_ORDER:      euler_order      <= cfg_data[4:0];
        q2e_pkg::CFG_GIMBAL_THRESHOLD: gimbal_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  logic       ord_frame, ord_rep, ord_par;
  logic [1:0] ax_i, ax_j, ax_k;

  always_comb begin
    ord_frame = euler_order[q2e_pkg::ORD_FRAME];
    ord_rep   = euler_order[q2e_pkg::ORD_REPEAT];
    ord_par   = euler_order[q2e_pkg::ORD_PARITY];
    // axis code three behaves as x
    ax_i = (euler_order[4:3] == 2'd3) ? 2'd0 : euler_order[4:3];
    ax_j = q2e_pkg::axis_succ(ax_i + {1'b0, ord_par});
    ax_k = q2e_pkg::axis_succ(ax_i + 2'd1 - {1'b0, ord_par});
  end

  // ---------------------------------------------------------------------
  // Pipeline control: every stage advances together; a held output stalls
  // the whole pipe so nothing is lost or repeated.
  // ---------------------------------------------------------------------
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: component products
  // ---------------------------------------------------------------------
  logic signed [15:0] in_w, in_x, in_y, in_z;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;

  assign in_w = s_tdata[15:0];
  assign in_x = s_tdata[31:16];
  assign in_y = s_tdata[47:32];
  assign in_z = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww <= in_w * in_w;
      p_xx <= in_x * in_x;
      p_yy <= in_y * in_y;
      p_zz <= in_z * in_z;
      p_xy <= in_x * in_y;
      p_wz <= in_w * in_z;
      p_xz <= in_x * in_z;
      p_wy <= in_w * in_y;
      p_yz <= in_y * in_z;
      p_wx <= in_w * in_x;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squared norm and half numerators of the nine matrix terms
  // (row-major; diagonal terms are subtracted from one later)
  // ---------------------------------------------------------------------
  logic signed [HW-1:0] hs_c [9];
  logic signed [HW-1:0] hs   [9];
  logic [NQW-1:0]       nq;

  always_comb begin
    hs_c[0] = HW'(p_yy) + HW'(p_zz);
    hs_c[1] = HW'(p_xy) - HW'(p_wz);
    hs_c[2] = HW'(p_xz) + HW'(p_wy);
    hs_c[3] = HW'(p_xy) + HW'(p_wz);
    hs_c[4] = HW'(p_xx) + HW'(p_zz);
    hs_c[5] = HW'(p_yz) - HW'(p_wx);
    hs_c[6] = HW'(p_xz) - HW'(p_wy);
    hs_c[7] = HW'(p_yz) + HW'(p_wx);
    hs_c[8] = HW'(p_xx) + HW'(p_yy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hs <= hs_c;
      nq <= NQW'($unsigned(p_ww)) + NQW'($unsigned(p_xx))
          + NQW'($unsigned(p_yy)) + NQW'($unsigned(p_zz));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3 and divider stages: round(|num| * 2^F / nq), one quotient bit
  // per stage, nine lanes side by side
  // ---------------------------------------------------------------------
  logic [RW-1:0]  dv_rem  [QW+1][9];
  logic [DVW-1:0] dv_dvd  [QW+1][9];
  logic [QW-1:0]  dv_q    [QW+1][9];
  logic [8:0]     dv_neg  [QW+1];
  logic [NQW-1:0] dv_nq   [QW+1];
  logic           dv_zero [QW+1];
  logic [DVW-1:0] dvd_c   [9];
  logic [8:0]     neg_c;

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      logic [HW-1:0] habs;
      neg_c[e] = hs[e][HW-1];
      habs     = neg_c[e] ? HW'(-hs[e]) : HW'(hs[e]);
      // dividend = 2*|half| * 2^F + nq/2
      dvd_c[e] = {habs, 1'b0, {F{1'b0}}} + DVW'(nq >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 9; e++) begin
        dv_dvd[0][e] <= dvd_c[e];
        dv_rem[0][e] <= RW'(dvd_c[e] >> QW);
        dv_q[0][e]   <= '0;
      end
      dv_neg[0]  <= neg_c;
      dv_nq[0]   <= nq;
      dv_zero[0] <= (nq == '0);
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int e = 0; e < 9; e++) begin
          logic [RW-1:0] t;
          t = {dv_rem[g][e][RW-2:0], dv_dvd[g][e][QW-1-g]};
          if (t >= RW'(dv_nq[g])) begin
            dv_rem[g+1][e] <= t - RW'(dv_nq[g]);
            dv_q[g+1][e]   <= {dv_q[g][e][QW-2:0], 1'b1};
          end else begin
            dv_rem[g+1][e] <= t;
            dv_q[g+1][e]   <= {dv_q[g][e][QW-2:0], 1'b0};
          end
          dv_dvd[g+1][e] <= dv_dvd[g][e];
        end
        dv_neg[g+1]  <= dv_neg[g];
        dv_nq[g+1]   <= dv_nq[g];
        dv_zero[g+1] <= dv_zero[g];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Matrix stage: apply sign, subtract diagonal terms from one, identity
  // for a zero quaternion
  // ---------------------------------------------------------------------
  localparam logic signed [QW:0] ONE_Q = (QW+1)'(1) << F;
  logic [8:0][MW-1:0] mat;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 9; e++) begin
        logic signed [QW:0] rr;
        logic signed [QW:0] val;
        rr = signed'({1'b0, dv_q[QW][e]});
        if (e == 0 || e == 4 || e == 8) begin
          val = dv_zero[QW] ? ONE_Q : ONE_Q - rr;
        end else begin
          val = dv_zero[QW] ? '0 : (dv_neg[QW][e] ? -rr : rr);
        end
        mat[e] <= MW'(val);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Select stage: pick the entries the configured order needs
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic signed [MW-1:0] y0n;  // first angle, regular branch
    logic signed [MW-1:0] x0n;
    logic signed [MW-1:0] y0l;  // first angle, singular branch
    logic signed [MW-1:0] x0l;
    logic signed [MW-1:0] y2;   // third angle
    logic signed [MW-1:0] x2;
    logic signed [MW-1:0] p1;   // partner of the magnitude for the second angle
  } side_t;

  function automatic logic signed [MW-1:0] pick(input logic [8:0][MW-1:0] m,
                                                input logic [1:0] r,
                                                input logic [1:0] c);
    logic [3:0] idx;
    idx = 4'(r) * 4'd3 + 4'(c);
    return signed'(m[idx]);
  endfunction

  logic signed [MW-1:0] sel_a, sel_b;
  side_t                sel_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [MW-1:0] e_ii, e_ij, e_ik, e_ji, e_jj, e_jk, e_ki, e_kj, e_kk;
      e_ii = pick(mat, ax_i, ax_i);
      e_ij = pick(mat, ax_i, ax_j);
      e_ik = pick(mat, ax_i, ax_k);
      e_ji = pick(mat, ax_j, ax_i);
      e_jj = pick(mat, ax_j, ax_j);
      e_jk = pick(mat, ax_j, ax_k);
      e_ki = pick(mat, ax_k, ax_i);
      e_kj = pick(mat, ax_k, ax_j);
      e_kk = pick(mat, ax_k, ax_k);
      sel_side.y0l <= MW'(-e_jk);
      sel_side.x0l <= e_jj;
      sel_side.y2  <= e_ji;
      if (ord_rep) begin
        sel_a        <= e_ij;
        sel_b        <= e_ik;
        sel_side.y0n <= e_ij;
        sel_side.x0n <= e_ik;
        sel_side.x2  <= MW'(-e_ki);
        sel_side.p1  <= e_ii;
      end else begin
        sel_a        <= e_ii;
        sel_b        <= e_ji;
        sel_side.y0n <= e_kj;
        sel_side.x0n <= e_kk;
        sel_side.x2  <= e_ii;
        sel_side.p1  <= MW'(-e_ki);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Squares, sum, then square root one result bit per stage
  // ---------------------------------------------------------------------
  logic [2*F:0]   sq_a, sq_b;
  side_t          sq_side;
  logic [SW-1:0]  sr_root [SW+1];
  logic [RMW-1:0] sr_rem  [SW+1];
  logic [2*SW-1:0] sr_val [SW+1];
  side_t          sr_side [SW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [2*MW-1:0] pa, pb;
      pa = sel_a * sel_a;
      pb = sel_b * sel_b;
      sq_a    <= (2*F+1)'(pa);
      sq_b    <= (2*F+1)'(pb);
      sq_side <= sel_side;
      sr_val[0]  <= (2*SW)'(sq_a) + (2*SW)'(sq_b);
      sr_root[0] <= '0;
      sr_rem[0]  <= '0;
      sr_side[0] <= sq_side;
    end
  end

  for (genvar s = 0; s < SW; s++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (adv) begin
        logic [RMW-1:0] t, trial;
        t     = {sr_rem[s][RMW-3:0], sr_val[s][2*(SW-1-s)+1 -: 2]};
        trial = RMW'({sr_root[s], 2'b01});
        if (t >= trial) begin
          sr_rem[s+1]  <= t - trial;
          sr_root[s+1] <= {sr_root[s][SW-2:0], 1'b1};
        end else begin
          sr_rem[s+1]  <= t;
          sr_root[s+1] <= {sr_root[s][SW-2:0], 1'b0};
        end
        sr_val[s+1]  <= sr_val[s];
        sr_side[s+1] <= sr_side[s];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Operand stage: gimbal test, then route the three atan2 operand pairs
  // ---------------------------------------------------------------------
  logic signed [MW-1:0] ar_y [3];
  logic signed [MW-1:0] ar_x [3];
  logic                 ar_lock;

  always_ff @(posedge clk) begin
    if (adv) begin
      logic                 lk;
      logic signed [MW-1:0] mg;
      lk = {sr_root[SW], 14'd0} <= (SW+14)'({gimbal_threshold, {F{1'b0}}});
      mg = signed'(MW'(sr_root[SW]));
      ar_lock <= lk;
      ar_y[0] <= lk ? sr_side[SW].y0l : sr_side[SW].y0n;
      ar_x[0] <= lk ? sr_side[SW].x0l : sr_side[SW].x0n;
      ar_y[1] <= ord_rep ? mg : sr_side[SW].p1;
      ar_x[1] <= ord_rep ? sr_side[SW].p1 : mg;
      ar_y[2] <= sr_side[SW].y2;
      ar_x[2] <= sr_side[SW].x2;
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC: prerotation into the right half plane, then one vectoring
  // iteration per stage on three lanes
  // ---------------------------------------------------------------------
  logic signed [XW-1:0] cx   [CS+1][3];
  logic signed [XW-1:0] cy   [CS+1][3];
  logic signed [ZW-1:0] cz   [CS+1][3];
  logic [2:0]           cyz  [CS+1];   // y operand was zero
  logic [2:0]           cxn  [CS+1];   // x operand was negative
  logic                 clk_lock [CS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        logic signed [XW-1:0] sx, sy;
        sx = XW'(ar_x[l]) <<< 8;
        sy = XW'(ar_y[l]) <<< 8;
        cyz[0][l] <= (ar_y[l] == '0);
        cxn[0][l] <= ar_x[l][MW-1];
        if (ar_x[l][MW-1]) begin
          cx[0][l] <= -sx;
          cy[0][l] <= -sy;
          cz[0][l] <= (ar_y[l] > 0) ? q2e_pkg::ANG_PI : -q2e_pkg::ANG_PI;
        end else begin
          cx[0][l] <= sx;
          cy[0][l] <= sy;
          cz[0][l] <= '0;
        end
      end
      clk_lock[0] <= ar_lock;
    end
  end

  for (genvar g = 0; g < CS; g++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          if (cy[g][l] > 0) begin
            cx[g+1][l] <= cx[g][l] + (cy[g][l] >>> g);
            cy[g+1][l] <= cy[g][l] - (cx[g][l] >>> g);
            cz[g+1][l] <= cz[g][l] + q2e_pkg::ATAN_TAB[g];
          end else begin
            cx[g+1][l] <= cx[g][l] - (cy[g][l] >>> g);
            cy[g+1][l] <= cy[g][l] + (cx[g][l] >>> g);
            cz[g+1][l] <= cz[g][l] - q2e_pkg::ATAN_TAB[g];
          end
        end
        cyz[g+1]      <= cyz[g];
        cxn[g+1]      <= cxn[g];
        clk_lock[g+1] <= clk_lock[g];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: round to radians*8192, clamp, zero the third angle on the
  // singular branch, apply parity and frame
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [15:0]   ang [3];
      for (int l = 0; l < 3; l++) begin
        logic signed [ZW-1:0] a, rs;
        logic signed [16:0]   r;
        if (cyz[CS][l]) begin
          a = cxn[CS][l] ? q2e_pkg::ANG_PI : '0;
        end else begin
          a = cz[CS][l];
        end
        rs = (a + ZW'(1024)) >>> 11;
        r  = 17'(rs);
        if (r > q2e_pkg::ANG_OUT_MAX) begin
          r = q2e_pkg::ANG_OUT_MAX;
        end else if (r < -q2e_pkg::ANG_OUT_MAX) begin
          r = -q2e_pkg::ANG_OUT_MAX;
        end
        if (l == 2 && clk_lock[CS]) begin
          r = '0;  // drop the third angle on the singular branch
        end
        if (ord_par) begin
          r = -r;
        end
        ang[l] = 16'(r);
      end
      if (ord_frame) begin
        m_tdata <= {ang[0], ang[1], ang[2]};
      end else begin
        m_tdata <= {ang[2], ang[1], ang[0]};
      end
      m_tuser <= clk_lock[CS];
    end
  end

endmodule
